### rtl/core/upe_pkg.sv
// Shared types, constants and helper functions of the URI percent encoder.
// Used by upe_front, upe_queue, upe_back and the top level; depends on nothing.

package upe_pkg;

    localparam logic [6:0] PCT_CHAR = 7'h25;

    localparam logic [1:0] CSET_UNRES = 2'd0;
    localparam logic [1:0] CSET_RES   = 2'd1;
    localparam logic [1:0] CSET_APOS  = 2'd2;
    localparam logic [1:0] CSET_BAD   = 2'd3;

    localparam logic REG_CHAR_SET = 1'b0;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_LIT,
        TAIL_PCT
    } tail_kind_t;

    // One command per input byte: a number of replacement characters followed
    // by an optional literal or a run of one to four escaped bytes.
    typedef struct packed {
        logic [2:0]      nbad;
        tail_kind_t      tail;
        logic [1:0]      tcnt;
        logic [3:0][7:0] tbytes;
    } cmd_t;

    typedef struct packed {
        logic       stp;
        logic [1:0] pc;
        logic [1:0] used;
        logic [2:0] nbad;
    } fst_t;

    function automatic logic [6:0] hex_char(input logic [3:0] v);
        logic [6:0] r;
        if (v < 4'd10) begin
            r = 7'h30 + {3'b000, v};
        end else begin
            r = 7'h37 + {3'b000, v};
        end
        return r;
    endfunction

    function automatic logic [7:0] repl_byte(input logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0: r = 8'hEF;
            2'd1: r = 8'hBF;
            2'd2: r = 8'hBD;
            default: r = 8'hBD;
        endcase
        return r;
    endfunction

    function automatic logic is_allowed(input logic [7:0] c, input logic [1:0] cset);
        logic unres;
        logic res;
        unres = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                (c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h2E ||
                c == 8'h5F || c == 8'h7E;
        case (c)
            8'h21, 8'h23, 8'h24, 8'h26, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C,
            8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5B, 8'h5D: res = 1'b1;
            default: res = 1'b0;
        endcase
        return unres || (cset >= CSET_RES && res) || (cset >= CSET_APOS && c == 8'h27);
    endfunction

    function automatic logic [2:0] seq_len(input logic [7:0] lead);
        logic [2:0] n;
        if (lead < 8'hE0) begin
            n = 3'd2;
        end else if (lead < 8'hF0) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

    function automatic logic is_overlong(input logic [7:0] lead, input logic [7:0] p1,
                                         input logic [2:0] n);
        logic r;
        case (n)
            3'd2: r = (lead[4:1] == 4'd0);
            3'd3: r = (lead[3:0] == 4'd0) && !p1[5];
            3'd4: r = (lead[2:0] == 3'd0) && (p1[5:4] == 2'd0);
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // The buffered lead gives one replacement; each further buffered byte
    // gives one more while the character budget lasts.
    function automatic fst_t fail_lead(input fst_t s, input logic [3:0] avail);
        fst_t r;
        r = s;
        r.nbad = r.nbad + 3'd1;
        if (s.pc > 2'd1 && !r.stp) begin
            if (avail[r.used]) begin
                r.used = r.used + 2'd1;
                r.nbad = r.nbad + 3'd1;
            end else begin
                r.stp = 1'b1;
            end
        end
        if (s.pc > 2'd2 && !r.stp) begin
            if (avail[r.used]) begin
                r.used = r.used + 2'd1;
                r.nbad = r.nbad + 3'd1;
            end else begin
                r.stp = 1'b1;
            end
        end
        r.pc = 2'd0;
        return r;
    endfunction

endpackage

### rtl/core/upe_front.sv
// Front end: accepts source bytes, tracks UTF-8 buffering and the character budget,
// and turns each byte into at most one command. Depends on upe_pkg.

module upe_front #(
    parameter int LIMIT_BITS = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_byte,
    input  logic [15:0]    char_limit,
    input  logic           end_of_string,
    input  logic [1:0]     char_set,
    input  logic           q_full,
    output logic           q_push,
    output upe_pkg::cmd_t  q_cmd
);

    localparam logic [32:0] LimMax = (33'd1 << LIMIT_BITS) - 33'd1;

    logic [7:0]            pend_reg [3];
    logic [7:0]            pend_next [3];
    logic [1:0]            pc_reg;
    logic [LIMIT_BITS-1:0] chars_left_reg;
    logic                  in_string_reg;
    logic                  stopped_reg;

    logic [32:0]           lim_wide;
    logic [LIMIT_BITS-1:0] lim_sat;
    logic [LIMIT_BITS-1:0] c_cur;
    logic [3:0]            avail;
    upe_pkg::fst_t         st;
    upe_pkg::cmd_t         cmd;
    logic                  do_start;
    logic [2:0]            n_len;
    logic                  accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        lim_wide = 33'(char_limit);
        lim_sat  = (lim_wide > LimMax) ? LimMax[LIMIT_BITS-1:0] : lim_wide[LIMIT_BITS-1:0];
        c_cur    = in_string_reg ? chars_left_reg : lim_sat;
        for (int k = 0; k < 4; k++) begin
            avail[k] = (c_cur > LIMIT_BITS'(k));
        end
    end

    always_comb begin
        st.stp   = in_string_reg && stopped_reg;
        st.pc    = in_string_reg ? pc_reg : 2'd0;
        st.used  = 2'd0;
        st.nbad  = 3'd0;
        cmd      = '0;
        cmd.tail = upe_pkg::TAIL_NONE;
        for (int i = 0; i < 3; i++) begin
            pend_next[i] = pend_reg[i];
        end
        do_start = 1'b0;
        n_len    = upe_pkg::seq_len(pend_reg[0]);

        if (!st.stp) begin
            if (in_byte == 8'd0) begin
                if (st.pc != 2'd0) begin
                    st = upe_pkg::fail_lead(st, avail);
                end
                st.stp = 1'b1;
                st.pc  = 2'd0;
            end else if (st.pc == 2'd0) begin
                do_start = 1'b1;
            end else if (in_byte[7:6] == 2'b10) begin
                if (({1'b0, st.pc} + 3'd1) >= n_len) begin
                    if (upe_pkg::is_overlong(pend_reg[0], pend_reg[1], n_len)) begin
                        st = upe_pkg::fail_lead(st, avail);
                        if (!st.stp) begin
                            if (avail[st.used]) begin
                                st.used = st.used + 2'd1;
                                st.nbad = st.nbad + 3'd1;
                            end else begin
                                st.stp = 1'b1;
                                st.pc  = 2'd0;
                            end
                        end
                    end else begin
                        cmd.tail      = upe_pkg::TAIL_PCT;
                        cmd.tcnt      = 2'(n_len - 3'd1);
                        cmd.tbytes[0] = pend_reg[0];
                        cmd.tbytes[1] = (n_len == 3'd2) ? in_byte : pend_reg[1];
                        cmd.tbytes[2] = (n_len == 3'd3) ? in_byte : pend_reg[2];
                        cmd.tbytes[3] = in_byte;
                        st.pc         = 2'd0;
                    end
                end else begin
                    case (st.pc)
                        2'd1: pend_next[1] = in_byte;
                        2'd2: pend_next[2] = in_byte;
                        default: ;
                    endcase
                    st.pc = st.pc + 2'd1;
                end
            end else begin
                st       = upe_pkg::fail_lead(st, avail);
                do_start = !st.stp;
            end
        end

        if (do_start) begin
            if (avail[st.used]) begin
                st.used = st.used + 2'd1;
                if (!in_byte[7]) begin
                    cmd.tail      = upe_pkg::is_allowed(in_byte, char_set) ?
                                    upe_pkg::TAIL_LIT : upe_pkg::TAIL_PCT;
                    cmd.tcnt      = 2'd0;
                    cmd.tbytes[0] = in_byte;
                end else if (in_byte[7:6] == 2'b10 || in_byte[7:3] == 5'b11111) begin
                    st.nbad = st.nbad + 3'd1;
                end else begin
                    pend_next[0] = in_byte;
                    st.pc        = 2'd1;
                end
            end else begin
                st.stp = 1'b1;
                st.pc  = 2'd0;
            end
        end

        if (end_of_string && !st.stp && st.pc != 2'd0) begin
            st = upe_pkg::fail_lead(st, avail);
        end

        cmd.nbad = st.nbad;
    end

    assign q_cmd  = cmd;
    assign q_push = accept && (cmd.nbad != 3'd0 || cmd.tail != upe_pkg::TAIL_NONE);

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < 3; i++) begin
                pend_reg[i] <= pend_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg         <= 2'd0;
            chars_left_reg <= '0;
            in_string_reg  <= 1'b0;
            stopped_reg    <= 1'b0;
        end else if (accept) begin
            in_string_reg  <= !end_of_string;
            stopped_reg    <= !end_of_string && st.stp;
            pc_reg         <= end_of_string ? 2'd0 : st.pc;
            chars_left_reg <= c_cur - LIMIT_BITS'(st.used);
        end
    end

endmodule

### rtl/core/upe_queue.sv
// Short command queue between the front end and the character sequencer.
// Depends on upe_pkg.

module upe_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  upe_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output upe_pkg::cmd_t head_cmd
);

    upe_pkg::cmd_t                 qbuf_reg [upe_pkg::QUEUE_DEPTH];
    logic [upe_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [upe_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [upe_pkg::QUEUE_PTR_W:0]   count_reg;

    assign full       = (count_reg == (upe_pkg::QUEUE_PTR_W + 1)'(upe_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = qbuf_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            qbuf_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/core/upe_back.sv
// Character sequencer: expands the head command into output characters, one per
// cycle unless the output stalls, into an output register. Depends on upe_pkg.

module upe_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          head_valid,
    input  upe_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [6:0]    out_char,
    output logic          out_last
);

    logic [2:0] bad_done_reg;
    logic [1:0] idx_reg;
    logic [1:0] sub_reg;
    logic       out_valid_reg;
    logic [6:0] out_char_reg;
    logic       out_last_reg;

    logic       adv;
    logic       in_bad;
    logic [7:0] cur_byte;
    logic [6:0] cur_char;
    logic       unit_end;
    logic       is_last;

    assign adv    = head_valid && (!out_valid_reg || out_ready);
    assign in_bad = (bad_done_reg < head_cmd.nbad);

    always_comb begin
        cur_byte = in_bad ? upe_pkg::repl_byte(idx_reg) : head_cmd.tbytes[idx_reg];
        case (sub_reg)
            2'd0: cur_char = upe_pkg::PCT_CHAR;
            2'd1: cur_char = upe_pkg::hex_char(cur_byte[7:4]);
            default: cur_char = upe_pkg::hex_char(cur_byte[3:0]);
        endcase
        if (!in_bad && head_cmd.tail == upe_pkg::TAIL_LIT) begin
            cur_char = head_cmd.tbytes[0][6:0];
        end

        if (in_bad) begin
            unit_end = (sub_reg == 2'd2) && (idx_reg == 2'd2);
            is_last  = unit_end && (bad_done_reg + 3'd1 == head_cmd.nbad) &&
                       (head_cmd.tail == upe_pkg::TAIL_NONE);
        end else if (head_cmd.tail == upe_pkg::TAIL_LIT) begin
            unit_end = 1'b1;
            is_last  = 1'b1;
        end else begin
            unit_end = (sub_reg == 2'd2) && (idx_reg == head_cmd.tcnt);
            is_last  = unit_end;
        end
    end

    assign pop       = adv && is_last;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_char_reg <= cur_char;
            out_last_reg <= is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bad_done_reg  <= 3'd0;
            idx_reg       <= 2'd0;
            sub_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (adv) begin
                if (is_last) begin
                    bad_done_reg <= 3'd0;
                    idx_reg      <= 2'd0;
                    sub_reg      <= 2'd0;
                end else if (in_bad && unit_end) begin
                    bad_done_reg <= bad_done_reg + 3'd1;
                    idx_reg      <= 2'd0;
                    sub_reg      <= 2'd0;
                end else if (sub_reg == 2'd2) begin
                    sub_reg <= 2'd0;
                    idx_reg <= idx_reg + 2'd1;
                end else begin
                    sub_reg <= sub_reg + 2'd1;
                end
            end
        end
    end

endmodule

### rtl/core/uri_percent_encoder_utf8_unit.sv
// Top level of the URI percent encoder with UTF-8 checking and its register port.
// Depends on upe_pkg, upe_front, upe_queue and upe_back.

// The block takes one source byte per word and sends the encoded string one ASCII
// character per word. The back end sends one character per cycle while the output
// is not stalled. A byte causes 1 character for a literal, 3 for an escaped byte,
// up to 12 for a complete UTF-8 sequence and 9 for each replacement character, up
// to 36 in all. The output channel sets the sustained rate; a two-entry command
// queue lets the front end run ahead of the output. m_tlast marks the last
// character caused by one input byte, and a byte that causes nothing produces no
// word at all.

module uri_percent_encoder_utf8_unit #(
    parameter int LIMIT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // in_byte [7:0], char_limit [23:8]
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_char [6:0], zero [7]
    output logic        m_tlast,   // run_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]    char_set_reg;
    logic          cfg_write;
    logic          q_full;
    logic          q_push;
    upe_pkg::cmd_t q_cmd;
    logic          q_pop;
    logic          head_valid;
    upe_pkg::cmd_t head_cmd;
    logic [6:0]    out_char;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == upe_pkg::REG_CHAR_SET);
    assign prdata    = (paddr[2] == upe_pkg::REG_CHAR_SET) ? {30'd0, char_set_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_set_reg <= upe_pkg::CSET_UNRES;
        end else if (cfg_write) begin
            char_set_reg <= (pwdata[1:0] == upe_pkg::CSET_BAD) ? upe_pkg::CSET_APOS : pwdata[1:0];
        end
    end

    upe_front #(
        .LIMIT_BITS(LIMIT_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_byte      (s_tdata[7:0]),
        .char_limit   (s_tdata[23:8]),
        .end_of_string(s_tlast),
        .char_set     (char_set_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    upe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .head_valid(head_valid),
        .head_cmd  (head_cmd)
    );

    upe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_valid(head_valid),
        .head_cmd  (head_cmd),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {1'b0, out_char};

endmodule

### rtl/core/upe_checker.sv
// Port-level checks for uri_percent_encoder_utf8_unit and the bind that attaches them.
// Depends on the top level's port list only.

module upe_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       pready
);

    // A stalled output word holds its character and marker.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // A percent sign always opens an escape and never ends the run of a byte.
    a_pct_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[6:0] == 7'h25 |-> !m_tlast && !m_tdata[7])
        else $error("percent sign closed a run");

    // After an accepted percent sign the next word is a hex digit that is not last.
    a_pct_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tdata[6:0] == 7'h25 |=>
        !m_tvalid || (!m_tlast && ((m_tdata[6:0] >= 7'h30 && m_tdata[6:0] <= 7'h39) ||
                                   (m_tdata[6:0] >= 7'h41 && m_tdata[6:0] <= 7'h46))))
        else $error("percent sign not followed by a high hex digit");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && pready)
        else $error("output valid right after reset");

endmodule

bind uri_percent_encoder_utf8_unit upe_checker u_upe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .pready  (pready)
);
